>>> rtl/core/crcfr_pkg.sv
// Shared types, codes and the CRC16-CCITT byte step for the framed receiver.
// Used by crcfr_ctrl, crcfr_dp and crc_checked_frame_receiver_core.
package crcfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;
  localparam int unsigned RESULT_CAP      = 64;
  localparam logic [15:0] CRC_POLY        = 16'h1021;

  localparam logic [7:0]  SYNC0_RST       = 8'hAA;
  localparam logic [7:0]  SYNC1_RST       = 8'h55;
  localparam logic [15:0] CRC_START_RST   = 16'hFFFF;
  localparam logic [6:0]  LIMIT_RST       = 7'd64;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SYNC0     = 2'd0,
    REG_SYNC1     = 2'd1,
    REG_CRC_START = 2'd2,
    REG_LIMIT     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OC_ACCEPT   = 2'd0,
    OC_CRC_BAD  = 2'd1,
    OC_DUP_SEQ  = 2'd2,
    OC_TOO_LONG = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    PH_SYNC0,
    PH_SYNC1,
    PH_HDR,
    PH_PAY,
    PH_CRC
  } phase_t;

  typedef enum logic [1:0] {
    CS_PARSE,
    CS_READ,
    CS_EMIT
  } ctl_state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_TOO_LONG,
    EMIT_CRC_BAD,
    EMIT_DUP,
    EMIT_EMPTY,
    EMIT_DATA
  } emit_t;

  typedef struct packed {
    logic  crc_init;
    logic  crc_update;
    logic  hold_type;
    logic  hold_seq;
    logic  hold_len;
    logic  hold_crc_low;
    logic  fc_clear;
    logic  fc_inc;
    logic  store_byte;
    logic  seq_commit;
    logic  rd_clear;
    logic  rd_inc;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic is_sync0;
    logic is_sync1;
    logic fc_zero;
    logic fc_one;
    logic rx_too_long;
    logic rx_zero;
    logic len_zero;
    logic pay_done;
    logic crc_ok;
    logic seq_dup;
    logic rd_last;
    logic out_free;
  } status_t;

  // One byte of CRC16-CCITT, MSB first, no reflection.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/core/crcfr_ctrl.sv
// Controller for the framed receiver: parser phase and emit sequencer.
// Depends on crcfr_pkg; drives crcfr_dp through cmd_t and reads status_t.
module crcfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_abort,
  output logic              in_ready,
  input  crcfr_pkg::status_t sts,
  output crcfr_pkg::cmd_t    cmd
);
  import crcfr_pkg::*;

  phase_t     phase_r, phase_nxt;
  ctl_state_t cs_r, cs_nxt;
  logic       fire;

  assign in_ready = (cs_r == CS_PARSE) && sts.out_free;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC0;
      cs_r    <= CS_PARSE;
    end else begin
      phase_r <= phase_nxt;
      cs_r    <= cs_nxt;
    end
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    cs_nxt    = cs_r;
    unique case (cs_r)
      CS_PARSE: begin
        if (fire && in_abort) begin
          phase_nxt = PH_SYNC0;
        end else if (fire) begin
          unique case (phase_r)
            PH_SYNC0: if (sts.is_sync0) phase_nxt = PH_SYNC1;
            PH_SYNC1: begin
              // Second sync is checked before a repeated first sync.
              if (sts.is_sync1)      phase_nxt = PH_HDR;
              else if (!sts.is_sync0) phase_nxt = PH_SYNC0;
            end
            PH_HDR: begin
              if (!sts.fc_zero && !sts.fc_one) begin
                if (sts.rx_too_long) phase_nxt = PH_SYNC0;
                else if (sts.rx_zero) phase_nxt = PH_CRC;
                else                  phase_nxt = PH_PAY;
              end
            end
            PH_PAY: if (sts.pay_done) phase_nxt = PH_CRC;
            PH_CRC: begin
              if (!sts.fc_zero) begin
                phase_nxt = PH_SYNC0;
                if (sts.crc_ok && !sts.seq_dup && !sts.len_zero) cs_nxt = CS_READ;
              end
            end
            default: phase_nxt = PH_SYNC0;
          endcase
        end
      end
      CS_READ: cs_nxt = CS_EMIT;
      CS_EMIT: begin
        if (sts.out_free) cs_nxt = sts.rd_last ? CS_PARSE : CS_READ;
      end
      default: cs_nxt = CS_PARSE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd      = '0;
    cmd.emit = EMIT_NONE;
    unique case (cs_r)
      CS_PARSE: begin
        if (fire && !in_abort) begin
          unique case (phase_r)
            PH_SYNC0: ;
            PH_SYNC1: begin
              if (sts.is_sync1) begin
                cmd.crc_init = 1'b1;
                cmd.fc_clear = 1'b1;
              end
            end
            PH_HDR: begin
              cmd.crc_update = 1'b1;
              if (sts.fc_zero) begin
                cmd.hold_type = 1'b1;
                cmd.fc_inc    = 1'b1;
              end else if (sts.fc_one) begin
                cmd.hold_seq = 1'b1;
                cmd.fc_inc   = 1'b1;
              end else begin
                cmd.fc_clear = 1'b1;
                if (sts.rx_too_long) cmd.emit = EMIT_TOO_LONG;
                else                 cmd.hold_len = 1'b1;
              end
            end
            PH_PAY: begin
              cmd.crc_update = 1'b1;
              cmd.store_byte = 1'b1;
              if (sts.pay_done) cmd.fc_clear = 1'b1;
              else              cmd.fc_inc   = 1'b1;
            end
            PH_CRC: begin
              if (sts.fc_zero) begin
                cmd.hold_crc_low = 1'b1;
                cmd.fc_inc       = 1'b1;
              end else begin
                cmd.fc_clear = 1'b1;
                if (!sts.crc_ok) begin
                  cmd.emit = EMIT_CRC_BAD;
                end else if (sts.seq_dup) begin
                  cmd.emit = EMIT_DUP;
                end else begin
                  cmd.seq_commit = 1'b1;
                  if (sts.len_zero) cmd.emit     = EMIT_EMPTY;
                  else              cmd.rd_clear = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      CS_READ: ;
      CS_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = EMIT_DATA;
          if (!sts.rd_last) cmd.rd_inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/crcfr_dp.sv
// Datapath for the framed receiver: config registers, CRC, header fields,
// payload memory and the output register. Depends on crcfr_pkg.
module crcfr_dp #(
  parameter int unsigned MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic [7:0]         rx_byte,
  input  crcfr_pkg::cmd_t    cmd,
  output crcfr_pkg::status_t sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_outcome,
  output logic [7:0]         out_frame_type,
  output logic [7:0]         out_seq_number,
  output logic [6:0]         out_payload_length,
  output logic [5:0]         out_byte_index,
  output logic [7:0]         out_payload_byte,
  output logic               out_has_data,
  output logic               out_seq_gap,
  output logic               out_last
);
  import crcfr_pkg::*;

  localparam int unsigned DEPTH = (MAX_PAYLOAD < RESULT_CAP) ? MAX_PAYLOAD : RESULT_CAP;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [6:0]  LEN_CAP = 7'(DEPTH);

  logic [7:0]  sync0_r, sync1_r;
  logic [15:0] crc_start_r;
  logic [6:0]  limit_r;

  logic [15:0] crc_r;
  logic [6:0]  fc_r;
  logic [7:0]  type_r, seq_r, crc_low_r, prev_seq_r;
  logic [6:0]  len_r;
  logic        prev_known_r, gap_r;
  logic [5:0]  rd_r;
  logic [7:0]  mem_q_r;
  logic [7:0]  mem [DEPTH];

  logic        out_valid_r, has_data_r, gap_out_r, last_r;
  logic [1:0]  outcome_r;
  logic [7:0]  frame_type_r, seq_out_r, pay_byte_r;
  logic [6:0]  len_out_r;
  logic [5:0]  idx_r;

  logic [6:0]  eff_limit;
  logic [7:0]  seq_delta;
  logic        gap_now;
  logic [7:0]  fc_plus1;
  logic [6:0]  rd_plus1;
  logic        out_free;

  assign eff_limit = (limit_r < LEN_CAP) ? limit_r : LEN_CAP;
  assign seq_delta = seq_r - prev_seq_r;
  assign gap_now   = prev_known_r && (seq_delta > 8'd1);
  assign fc_plus1  = {1'b0, fc_r} + 8'd1;
  assign rd_plus1  = {1'b0, rd_r} + 7'd1;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    sts.is_sync0    = (rx_byte == sync0_r);
    sts.is_sync1    = (rx_byte == sync1_r);
    sts.fc_zero     = (fc_r == 7'd0);
    sts.fc_one      = (fc_r == 7'd1);
    sts.rx_too_long = (rx_byte > {1'b0, eff_limit});
    sts.rx_zero     = (rx_byte == 8'd0);
    sts.len_zero    = (len_r == 7'd0);
    sts.pay_done    = (fc_plus1 >= {1'b0, len_r});
    sts.crc_ok      = ({rx_byte, crc_low_r} == crc_r);
    sts.seq_dup     = prev_known_r && (seq_delta == 8'd0);
    sts.rd_last     = (rd_plus1 == len_r);
    sts.out_free    = out_free;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync0_r     <= SYNC0_RST;
      sync1_r     <= SYNC1_RST;
      crc_start_r <= CRC_START_RST;
      limit_r     <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SYNC0:     sync0_r     <= cfg_wdata[7:0];
        REG_SYNC1:     sync1_r     <= cfg_wdata[7:0];
        REG_CRC_START: crc_start_r <= cfg_wdata;
        REG_LIMIT:     limit_r     <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Control counters and sequence history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r         <= '0;
      rd_r         <= '0;
      prev_known_r <= 1'b0;
      prev_seq_r   <= '0;
      gap_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.fc_clear)    fc_r <= '0;
      else if (cmd.fc_inc) fc_r <= fc_plus1[6:0];
      if (cmd.rd_clear)    rd_r <= '0;
      else if (cmd.rd_inc) rd_r <= rd_plus1[5:0];
      if (cmd.seq_commit) begin
        prev_known_r <= 1'b1;
        prev_seq_r   <= seq_r;
        gap_r        <= gap_now;
      end
      if (cmd.emit != EMIT_NONE) out_valid_r <= 1'b1;
      else if (out_ready)        out_valid_r <= 1'b0;
    end
  end

  // Header fields, CRC and payload memory.
  always_ff @(posedge clk) begin
    if (cmd.crc_init)          crc_r <= crc_start_r;
    else if (cmd.crc_update)   crc_r <= crc16_step(crc_r, rx_byte);
    if (cmd.hold_type)         type_r    <= rx_byte;
    if (cmd.hold_seq)          seq_r     <= rx_byte;
    if (cmd.hold_len)          len_r     <= rx_byte[6:0];
    if (cmd.hold_crc_low)      crc_low_r <= rx_byte;
    if (cmd.store_byte)        mem[fc_r[AW-1:0]] <= rx_byte;
    mem_q_r <= mem[rd_r[AW-1:0]];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      frame_type_r <= type_r;
      seq_out_r    <= seq_r;
      len_out_r    <= len_r;
      idx_r        <= '0;
      pay_byte_r   <= '0;
      has_data_r   <= 1'b0;
      gap_out_r    <= 1'b0;
      last_r       <= 1'b1;
      unique case (cmd.emit)
        EMIT_TOO_LONG: begin
          outcome_r <= OC_TOO_LONG;
          len_out_r <= rx_byte[7] ? 7'h7F : rx_byte[6:0];
        end
        EMIT_CRC_BAD: outcome_r <= OC_CRC_BAD;
        EMIT_DUP:     outcome_r <= OC_DUP_SEQ;
        EMIT_EMPTY: begin
          outcome_r <= OC_ACCEPT;
          gap_out_r <= gap_now;
        end
        EMIT_DATA: begin
          outcome_r  <= OC_ACCEPT;
          idx_r      <= rd_r;
          pay_byte_r <= mem_q_r;
          has_data_r <= 1'b1;
          gap_out_r  <= gap_r;
          last_r     <= sts.rd_last;
        end
        default: outcome_r <= OC_ACCEPT;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = outcome_r;
  assign out_frame_type     = frame_type_r;
  assign out_seq_number     = seq_out_r;
  assign out_payload_length = len_out_r;
  assign out_byte_index     = idx_r;
  assign out_payload_byte   = pay_byte_r;
  assign out_has_data       = has_data_r;
  assign out_seq_gap        = gap_out_r;
  assign out_last           = last_r;

endmodule

>>> rtl/core/crc_checked_frame_receiver_core.sv
// A status or empty-frame item appears in the output register in the cycle after the input
// item that completes the frame. A good frame's payload follows byte by byte, paced by the
// payload memory's registered read and then the output register. Throughput: one input item
// per cycle while parsing and the output register is free; input is held off while a payload
// of N bytes is emitted. Reset (rst_n, synchronous, active low) restores the register
// defaults, returns to sync hunt and clears sequence history; no memory clearing.
module crc_checked_frame_receiver_core #(
  parameter int unsigned MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] stall_abort
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] frame_type, [15:8] seq_number,
                                  // [22:16] payload_length, [28:23] byte_index,
                                  // [36:29] payload_byte, [37] seq_gap, [39:38] zero
  output logic [2:0]  out_tuser,  // [1:0] outcome, [2] has_data
  output logic        out_tlast
);
  import crcfr_pkg::*;

  cmd_t       cmd;
  status_t    sts;
  logic [1:0] outcome;
  logic [7:0] frame_type, seq_number, payload_byte;
  logic [6:0] payload_length;
  logic [5:0] byte_index;
  logic       has_data, seq_gap;

  crcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_abort (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  crcfr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .rx_byte            (in_tdata),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_tready),
    .out_valid          (out_tvalid),
    .out_outcome        (outcome),
    .out_frame_type     (frame_type),
    .out_seq_number     (seq_number),
    .out_payload_length (payload_length),
    .out_byte_index     (byte_index),
    .out_payload_byte   (payload_byte),
    .out_has_data       (has_data),
    .out_seq_gap        (seq_gap),
    .out_last           (out_tlast)
  );

  assign out_tdata = {2'b00, seq_gap, payload_byte, byte_index, payload_length,
                      seq_number, frame_type};
  assign out_tuser = {has_data, outcome};

`ifndef SYNTHESIS
  // A stalled result must never be overwritten by a new input item.
  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while output register is blocked");

  // Payload data only ever belongs to accepted frames.
  a_data_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tuser[1:0] == OC_ACCEPT))
    else $error("payload item with a failure outcome");

  // Every failure status is a single, final item.
  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[1:0] != OC_ACCEPT)) |-> (out_tlast && !out_tuser[2]))
    else $error("status item not marked last");
`endif

endmodule
